>>> rtl/mtsb_pkg.sv
// Shared types, codes and sizes for the timer slot bank.
// Used by the controller, the datapath, the top level and the checker.
package mtsb_pkg;

	localparam int TIMER_SLOTS   = 32;
	localparam int CHANNEL_COUNT = 16;
	localparam int MAX_RESULTS   = 32;

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	// command codes on func
	localparam logic [2:0] FN_ALLOC = 3'd0;
	localparam logic [2:0] FN_FREE  = 3'd1;
	localparam logic [2:0] FN_BIND  = 3'd2;
	localparam logic [2:0] FN_ARM   = 3'd3;
	localparam logic [2:0] FN_TICK  = 3'd4;

	// slot status codes
	localparam logic [1:0] ST_FREE  = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_EXPIRE = 2'd1;
	localparam logic [1:0] KIND_IDLE   = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic accept;      // command transaction taken this cycle
		logic alloc_step;  // test one slot for allocate
		logic tick_issue;  // read one slot into the tick pipeline
		logic tick_fin;    // deliver the final tick result
	} mtsb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic idx_last;    // walk index is on the last slot
		logic alloc_hit;   // slot under the walk index is free
	} mtsb_stat_t;

endpackage

>>> rtl/mtsb_ctrl.sv
// Sequencer for the timer slot bank: slot walks for allocate and tick.
// Depends on mtsb_pkg.
module mtsb_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [2:0]             func,
	input  mtsb_pkg::mtsb_stat_t   stat,
	output mtsb_pkg::mtsb_cmd_t    cmd,
	output logic                   busy
);
	import mtsb_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ALLOC = 3'd1;
	localparam logic [2:0] S_TICK  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_nxt      = state_q;
		cmd            = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = start;
				if (start) begin
					if (func == FN_ALLOC)
						state_nxt = S_ALLOC;
					else if (func == FN_TICK)
						state_nxt = S_TICK;
				end
			end
			S_ALLOC: begin
				cmd.alloc_step = 1'b1;
				if (stat.alloc_hit || stat.idx_last)
					state_nxt = S_IDLE;
			end
			S_TICK: begin
				cmd.tick_issue = 1'b1;
				if (stat.idx_last)
					state_nxt = S_DRAIN;
			end
			S_DRAIN: begin
				state_nxt = S_FIN;
			end
			S_FIN: begin
				cmd.tick_fin = 1'b1;
				state_nxt    = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

endmodule

>>> rtl/mtsb_dp.sv
// Datapath of the timer slot bank: slot status, countdown and binding
// memories, tick pipeline, pending expiry and result register. Uses mtsb_pkg.
module mtsb_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mtsb_pkg::mtsb_cmd_t    cmd,
	output mtsb_pkg::mtsb_stat_t   stat,
	input  logic [2:0]             func,
	input  logic [4:0]             slot,
	input  logic [3:0]             channel,
	input  logic [7:0]             payload,
	input  logic [31:0]            timeout,
	output logic                   strobe,
	output logic [1:0]             kind,
	output logic [4:0]             slot_index,
	output logic                   found,
	output logic [3:0]             out_channel,
	output logic [7:0]             out_payload,
	output logic [31:0]            tick_total,
	output logic                   last
);
	import mtsb_pkg::*;

	// slot status in flops (reset to free), the rest in memories
	logic [1:0]  status_q [TIMER_SLOTS];
	logic [31:0] rem_mem  [TIMER_SLOTS];
	logic [11:0] bind_mem [TIMER_SLOTS];

	logic [IDX_W-1:0] idx_q;
	logic [31:0]      tick_q;
	logic [CNT_W-1:0] exp_cnt_q;

	// tick pipeline stage 1
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             run_s1;
	logic [31:0]      rem_s1;
	logic [11:0]      bind_s1;

	// one expiry held back until it is known whether it is the last
	logic             pend_vld_q;
	logic [IDX_W-1:0] pend_idx_q;
	logic [11:0]      pend_bind_q;

	logic             strobe_q;
	logic [1:0]       kind_q;
	logic [4:0]       slot_index_q;
	logic             found_q;
	logic [11:0]      bind_out_q;
	logic [31:0]      tick_total_q;
	logic             last_q;

	logic [IDX_W-1:0] slot_idx;
	logic             slot_ok, chan_ok;
	logic             do_free, do_bind, do_arm, do_tick;
	logic             alloc_take;
	logic             s1_run, s1_one, s1_dec, s1_hit;
	logic             rem_we;
	logic [IDX_W-1:0] rem_wa;
	logic [31:0]      rem_wd;

	logic             emit;
	logic [1:0]       kind_nxt;
	logic [4:0]       slot_index_nxt;
	logic             found_nxt;
	logic [11:0]      bind_nxt;
	logic [31:0]      tick_total_nxt;
	logic             last_nxt;

	assign slot_idx = IDX_W'(slot);
	assign slot_ok  = (7'(slot) < 7'(TIMER_SLOTS));
	assign chan_ok  = (9'(channel) < 9'(CHANNEL_COUNT));
	assign do_free  = cmd.accept && (func == FN_FREE) && slot_ok;
	assign do_bind  = cmd.accept && (func == FN_BIND) && slot_ok && chan_ok;
	assign do_arm   = cmd.accept && (func == FN_ARM) && slot_ok;
	assign do_tick  = cmd.accept && (func == FN_TICK);

	assign stat.alloc_hit = (status_q[idx_q] == ST_FREE);
	assign stat.idx_last  = (idx_q == IDX_W'(TIMER_SLOTS - 1));
	assign alloc_take     = cmd.alloc_step && stat.alloc_hit;

	// countdown: a slot due to expire past the result limit waits a tick
	assign s1_run = vld_s1 && run_s1;
	assign s1_one = (rem_s1 == 32'd1);
	assign s1_dec = s1_run && !(s1_one && (exp_cnt_q >= CNT_W'(MAX_RESULTS)));
	assign s1_hit = s1_dec && s1_one;

	assign rem_we = do_arm || s1_dec;
	assign rem_wa = do_arm ? slot_idx : idx_s1;
	assign rem_wd = do_arm ? timeout : (rem_s1 - 32'd1);

	always_comb begin
		emit           = 1'b0;
		kind_nxt       = KIND_ALLOC;
		slot_index_nxt = '0;
		found_nxt      = 1'b0;
		bind_nxt       = '0;
		tick_total_nxt = '0;
		last_nxt       = 1'b0;
		if (cmd.alloc_step) begin
			if (stat.alloc_hit) begin
				emit           = 1'b1;
				slot_index_nxt = 5'(idx_q);
				found_nxt      = 1'b1;
				last_nxt       = 1'b1;
			end else if (stat.idx_last) begin
				emit     = 1'b1;
				last_nxt = 1'b1;
			end
		end else if (s1_hit && pend_vld_q) begin
			emit           = 1'b1;
			kind_nxt       = KIND_EXPIRE;
			slot_index_nxt = 5'(pend_idx_q);
			bind_nxt       = pend_bind_q;
			tick_total_nxt = tick_q;
		end else if (cmd.tick_fin) begin
			emit           = 1'b1;
			last_nxt       = 1'b1;
			tick_total_nxt = tick_q;
			if (pend_vld_q) begin
				kind_nxt       = KIND_EXPIRE;
				slot_index_nxt = 5'(pend_idx_q);
				bind_nxt       = pend_bind_q;
			end else begin
				kind_nxt = KIND_IDLE;
			end
		end
	end

	// status flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMER_SLOTS; i++)
				status_q[i] <= ST_FREE;
		end else begin
			if (do_free)
				status_q[slot_idx] <= ST_FREE;
			else if (do_arm)
				status_q[slot_idx] <= ST_RUN;
			else if (alloc_take)
				status_q[idx_q] <= ST_ALLOC;
			else if (s1_hit)
				status_q[idx_s1] <= ST_ALLOC;
		end
	end

	// memories, read data registered into stage 1
	always_ff @(posedge clk) begin
		if (rem_we)
			rem_mem[rem_wa] <= rem_wd;
		if (do_bind)
			bind_mem[slot_idx] <= {channel, payload};
		rem_s1  <= rem_mem[idx_q];
		bind_s1 <= bind_mem[idx_q];
		idx_s1  <= idx_q;
		run_s1  <= (status_q[idx_q] == ST_RUN);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			tick_q     <= '0;
			exp_cnt_q  <= '0;
			vld_s1     <= 1'b0;
			pend_vld_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			vld_s1   <= cmd.tick_issue;
			strobe_q <= emit;
			if (cmd.accept)
				idx_q <= '0;
			else if (cmd.alloc_step || cmd.tick_issue)
				idx_q <= idx_q + 1'b1;
			if (do_tick) begin
				tick_q     <= tick_q + 32'd1;
				exp_cnt_q  <= '0;
				pend_vld_q <= 1'b0;
			end else begin
				if (s1_hit) begin
					exp_cnt_q  <= exp_cnt_q + 1'b1;
					pend_vld_q <= 1'b1;
				end else if (cmd.tick_fin) begin
					pend_vld_q <= 1'b0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s1_hit) begin
			pend_idx_q  <= idx_s1;
			pend_bind_q <= bind_s1;
		end
		if (emit) begin
			kind_q       <= kind_nxt;
			slot_index_q <= slot_index_nxt;
			found_q      <= found_nxt;
			bind_out_q   <= bind_nxt;
			tick_total_q <= tick_total_nxt;
			last_q       <= last_nxt;
		end
	end

	assign strobe      = strobe_q;
	assign kind        = kind_q;
	assign slot_index  = slot_index_q;
	assign found       = found_q;
	assign out_channel = bind_out_q[11:8];
	assign out_payload = bind_out_q[7:0];
	assign tick_total  = tick_total_q;
	assign last        = last_q;

endmodule

>>> rtl/multi_timer_slot_bank.sv
// Top level of the timer slot bank: controller plus datapath.
// Depends on mtsb_pkg, mtsb_ctrl and mtsb_dp.
//
// Channel   Handshake           Fields
// -------   ---------           ------
// command   start & !busy       func, slot, channel, payload, timeout
// result    strobe (one cycle)  kind, slot_index, found, out_channel,
//                               out_payload, tick_total, last
//
// Free, bind and arm give no result; busy stays low.
// Allocate walks the status flops one slot per cycle; the reply is
// registered and shows in the cycle after the hit.
// Tick walks every slot through a two-stage read/decrement pipeline on the
// countdown memory port.
// Reset clears every slot to free and the tick count to zero, at once.
// Results cannot be held off: each is shown for exactly one cycle.
module multi_timer_slot_bank (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [4:0]  slot,
	input  logic [3:0]  channel,
	input  logic [7:0]  payload,
	input  logic [31:0] timeout,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [4:0]  slot_index,
	output logic        found,
	output logic [3:0]  out_channel,
	output logic [7:0]  out_payload,
	output logic [31:0] tick_total,
	output logic        last
);
	import mtsb_pkg::*;

	mtsb_cmd_t  cmd;   // sequencer commands
	mtsb_stat_t stat;  // walk status back to sequencer

	// sequencer: idle / allocate walk / tick walk, drain, final result
	mtsb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// slot storage, countdown pipeline and result register
	mtsb_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.func        (func),
		.slot        (slot),
		.channel     (channel),
		.payload     (payload),
		.timeout     (timeout),
		.strobe      (strobe),
		.kind        (kind),
		.slot_index  (slot_index),
		.found       (found),
		.out_channel (out_channel),
		.out_payload (out_payload),
		.tick_total  (tick_total),
		.last        (last)
	);

endmodule

>>> rtl/mtsb_checker.sv
// Port-level checks for the timer slot bank, bound to the top level.
// Depends on mtsb_pkg.
module mtsb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  func,
	input logic        strobe,
	input logic [1:0]  kind,
	input logic [4:0]  slot_index,
	input logic        last
);
	import mtsb_pkg::*;

	// a final result is never followed directly by another result
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result right after final result");

	// intermediate expiries only appear while the transaction is in flight
	a_mid_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy && kind == KIND_EXPIRE)
		else $error("intermediate result outside a tick");

	// allocate replies and idle markers are single results
	a_single_reply: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == KIND_ALLOC || kind == KIND_IDLE) |-> last)
		else $error("single-result reply without last");

	// idle marker carries no slot
	a_idle_marker: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_IDLE |-> slot_index == 5'd0)
		else $error("idle marker with slot index");

	// free, bind and arm produce no result and leave busy low next cycle
	a_silent_cmds: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func == FN_FREE || func == FN_BIND || func == FN_ARM)
		|=> !strobe && !busy)
		else $error("result or busy after silent command");

endmodule

bind multi_timer_slot_bank mtsb_checker u_mtsb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.func       (func),
	.strobe     (strobe),
	.kind       (kind),
	.slot_index (slot_index),
	.last       (last)
);
